>>> sv/rds_text_assembler_core_macros.svh
// Assertion macros shared by the RDS text assembler modules.
`ifndef RDS_TEXT_ASSEMBLER_CORE_MACROS_SVH
`define RDS_TEXT_ASSEMBLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDSTA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDSTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/rdsta_pkg.sv
// Types, constants and helper functions for the RDS text assembler.
`default_nettype none

package rdsta_pkg;

   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 72;
   localparam int CHUNK_W     = 3;
   localparam int CHARS_W     = 64;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [3:0] GROUP_PS    = 4'h0;
   localparam logic [3:0] GROUP_RT    = 4'h2;
   localparam int         VERSION_BIT = 11;

   localparam logic TEXT_KIND_PS = 1'b0;
   localparam logic TEXT_KIND_RT = 1'b1;

   localparam logic [CHUNK_W-1:0] LAST_CHUNK = 3'd7;

   localparam logic [7:0] PRINT_LOW  = 8'd31;
   localparam logic [7:0] PRINT_HIGH = 8'd127;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // One classified group waiting for the back end.
   typedef struct packed {
      logic        is_rt;
      logic [3:0]  segment;
      logic [15:0] word_c;
      logic [15:0] word_d;
   } rdsta_cmd_type;

   typedef struct packed {
      logic          valid;
      rdsta_cmd_type cmd;
   } rdsta_qpush_type;

   typedef struct packed {
      logic          valid;
      rdsta_cmd_type cmd;
   } rdsta_qhead_type;

   // Program-service bytes outside the printable range are shown as spaces.
   function automatic logic [7:0] ps_printable(input logic [7:0] c);
      ps_printable = (c > PRINT_LOW && c < PRINT_HIGH) ? c : SPACE_CHAR;
   endfunction

endpackage

`default_nettype wire

>>> sv/rdsta_front.sv
// Front end: takes group beats, drops unused groups and queues the rest.
`default_nettype none

module rdsta_front (
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [rdsta_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  wire logic                                queue_full,
   output rdsta_pkg::rdsta_qpush_type               push
);

   logic [15:0] block_b;
   logic [15:0] block_c;
   logic [15:0] block_d;
   logic [3:0]  group_type;
   logic        wanted;

   assign block_b    = req_tdata[15:0];
   assign block_c    = req_tdata[31:16];
   assign block_d    = req_tdata[47:32];
   assign group_type = block_b[15:12];

   // Only version A groups of type 0 or 2 carry text that we keep.
   assign wanted = !block_b[rdsta_pkg::VERSION_BIT] &&
                   (group_type == rdsta_pkg::GROUP_PS || group_type == rdsta_pkg::GROUP_RT);

   assign req_tready = !queue_full;

   always_comb begin
      push.valid       = req_tvalid && req_tready && wanted;
      push.cmd.is_rt   = (group_type == rdsta_pkg::GROUP_RT);
      push.cmd.segment = block_b[3:0];
      push.cmd.word_c  = block_c;
      push.cmd.word_d  = block_d;
   end

endmodule

`default_nettype wire

>>> sv/rdsta_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

`include "rds_text_assembler_core_macros.svh"

module rdsta_queue #(
   parameter int DEPTH = rdsta_pkg::QUEUE_DEPTH
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rdsta_pkg::rdsta_qpush_type push,
   output logic                            full,
   input  wire logic                       pop,
   output rdsta_pkg::rdsta_qhead_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rdsta_pkg::rdsta_cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push.valid ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   `RDSTA_ASSERT_SAME(a_pop_nonempty, clock, reset, pop, count_ff != '0, "pop from empty queue")
   `RDSTA_ASSERT_SAME(a_push_room, clock, reset, push.valid, !full || pop, "push into full queue")

endmodule

`default_nettype wire

>>> sv/rdsta_back.sv
// Back end: text stores, read-out sequencer and result register.
`default_nettype none

`include "rds_text_assembler_core_macros.svh"

module rdsta_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire rdsta_pkg::rdsta_qhead_type          head,
   output logic                                     head_pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [rdsta_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [0:0]                               rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_PS_OUT = 2'd1;
   localparam logic [1:0] ST_RT_RD  = 2'd2;
   localparam logic [1:0] ST_RT_OUT = 2'd3;

   localparam int CW = rdsta_pkg::CHUNK_W;
   localparam int XW = rdsta_pkg::CHARS_W;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] chunk_ff, chunk_in;

   logic [7:0]  ps_ff [8];
   logic        ps_we;
   logic [XW-1:0] ps_chars;

   // Radiotext: even segments in the upper half of a chunk, odd in the lower.
   logic [31:0] rt_hi_mem [8];
   logic [31:0] rt_lo_mem [8];
   logic [15:0] rt_valid_ff;
   logic        rt_we;
   logic        rd_en;
   logic [CW-1:0] rd_addr;
   logic [31:0] rd_hi_ff, rd_lo_ff;
   logic        rd_vhi_ff, rd_vlo_ff;
   logic [XW-1:0] rt_chars;

   logic          out_free;
   logic          load;
   logic          load_kind;
   logic [CW-1:0] load_chunk;
   logic [XW-1:0] load_chars;
   logic          load_last;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff;
   logic [CW-1:0] rsp_chunk_ff;
   logic [XW-1:0] rsp_chars_ff;
   logic          rsp_last_ff;

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         ps_chars[XW-1-8*i -: 8] = rdsta_pkg::ps_printable(ps_ff[i]);
      end
   end

   assign rt_chars = {rd_vhi_ff ? rd_hi_ff : 32'h0, rd_vlo_ff ? rd_lo_ff : 32'h0};
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      chunk_in   = chunk_ff;
      head_pop   = 1'b0;
      ps_we      = 1'b0;
      rt_we      = 1'b0;
      rd_en      = 1'b0;
      rd_addr    = chunk_ff;
      load       = 1'b0;
      load_kind  = rdsta_pkg::TEXT_KIND_PS;
      load_chunk = '0;
      load_chars = ps_chars;
      load_last  = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               head_pop = 1'b1;
               if (head.cmd.is_rt) begin
                  rt_we    = 1'b1;
                  chunk_in = '0;
                  state_in = ST_RT_RD;
               end else begin
                  ps_we    = 1'b1;
                  state_in = ST_PS_OUT;
               end
            end
         end
         ST_PS_OUT: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_RT_RD: begin
            rd_en    = 1'b1;
            rd_addr  = chunk_ff;
            state_in = ST_RT_OUT;
         end
         ST_RT_OUT: begin
            load_kind  = rdsta_pkg::TEXT_KIND_RT;
            load_chunk = chunk_ff;
            load_chars = rt_chars;
            load_last  = (chunk_ff == rdsta_pkg::LAST_CHUNK);
            if (out_free) begin
               load = 1'b1;
               if (load_last) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = chunk_ff + 1'b1;
                  chunk_in = chunk_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chunk_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rt_valid_ff  <= '0;
         for (int i = 0; i < 8; i++) begin
            ps_ff[i] <= 8'h00;
         end
      end else begin
         state_ff     <= state_in;
         chunk_ff     <= chunk_in;
         rsp_valid_ff <= rsp_valid_in;
         if (rt_we) begin
            rt_valid_ff[head.cmd.segment] <= 1'b1;
         end
         if (ps_we) begin
            ps_ff[{head.cmd.segment[1:0], 1'b0}] <= head.cmd.word_d[15:8];
            ps_ff[{head.cmd.segment[1:0], 1'b1}] <= head.cmd.word_d[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rt_we && !head.cmd.segment[0]) begin
         rt_hi_mem[head.cmd.segment[3:1]] <= {head.cmd.word_c, head.cmd.word_d};
      end
      if (rt_we && head.cmd.segment[0]) begin
         rt_lo_mem[head.cmd.segment[3:1]] <= {head.cmd.word_c, head.cmd.word_d};
      end
      if (rd_en) begin
         rd_hi_ff  <= rt_hi_mem[rd_addr];
         rd_lo_ff  <= rt_lo_mem[rd_addr];
         rd_vhi_ff <= rt_valid_ff[{rd_addr, 1'b0}];
         rd_vlo_ff <= rt_valid_ff[{rd_addr, 1'b1}];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_kind_ff  <= load_kind;
         rsp_chunk_ff <= load_chunk;
         rsp_chars_ff <= load_chars;
         rsp_last_ff  <= load_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(rdsta_pkg::RSP_DATA_W - CW - XW)'(0), rsp_chars_ff, rsp_chunk_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   `RDSTA_ASSERT_SAME(a_pop_idle, clock, reset, head_pop, state_ff == ST_IDLE, "pop while busy")
   `RDSTA_ASSERT_NEXT(a_last_idle, clock, reset, load && load_last, state_ff == ST_IDLE, "busy after last")
   `RDSTA_ASSERT_SAME(a_ps_single, clock, reset, rsp_valid_ff && rsp_kind_ff == rdsta_pkg::TEXT_KIND_PS, rsp_last_ff && rsp_chunk_ff == '0, "name result not single")

endmodule

`default_nettype wire

>>> sv/rds_text_assembler_core.sv
// Top level of the RDS program-service and radiotext assembler.
`default_nettype none

// Each request beat carries one received RDS group (blocks B, C and D). Version A groups of
// type 0 update two characters of the 8-character program-service name and produce one result
// beat holding the whole name, with non-printable bytes shown as spaces; version A groups of
// type 2 update four characters of the 64-character radiotext and produce eight result beats,
// chunks 0 to 7, the last marked with tlast. All other groups are taken and dropped. The front
// end classifies a group in the cycle it is accepted and places it in a small queue
// (QUEUE_DEPTH groups), so new groups keep arriving while the back end is busy. The back end
// handles one group at a time: a name group takes one store write and then its result beat;
// a radiotext group takes one store write, one memory read, then one chunk a cycle while the
// output is not stalled. The name store resets to zero bytes, shown as spaces; the radiotext
// store reads zeros after reset with no clearing pass; back-pressure holds the sequencer.

module rds_text_assembler_core #(
   parameter int QUEUE_DEPTH = rdsta_pkg::QUEUE_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // block_b [15:0], block_c [31:16], block_d [47:32]
   input  wire logic [rdsta_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // chunk_index [2:0], chars [66:3], zero fill [71:67]
   output logic [rdsta_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // text_kind [0]
   output logic [0:0]                             rsp_tuser,
   output logic                                   rsp_tlast
);

   rdsta_pkg::rdsta_qpush_type push;
   rdsta_pkg::rdsta_qhead_type head;
   logic                       queue_full;
   logic                       head_pop;

   rdsta_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push)
   );

   rdsta_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .pop   (head_pop),
      .head  (head)
   );

   rdsta_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
